### sv/octnrm_pkg.sv
// ----------------------------------------------------------------------------
// Octahedral normal encoder package
// Widths, constants and payload types shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package octnrm_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int OUT_WIDTH = 16;

  // Magnitude of one component, L1 norm, numerator (up to 2L) and dividend.
  localparam int MAG_W = IN_WIDTH;
  localparam int L_W   = IN_WIDTH + 1;
  localparam int NUM_W = IN_WIDTH + 2;
  localparam int DVD_W = NUM_W + OUT_WIDTH;

  // Divider stages, one quotient bit each, plus the three front stages.
  localparam int DIV_STAGES = OUT_WIDTH;
  localparam int LATENCY    = 3 + DIV_STAGES;

  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};
  localparam logic [OUT_WIDTH-1:0] OUT_MID = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] enc_u;
    logic [OUT_WIDTH-1:0] enc_v;
    logic                 zero_vector;
  } out_item_t;

  // Hand-off from the front end to the divider.
  typedef struct packed {
    logic             zero;
    logic [NUM_W-1:0] divisor;
    logic [DVD_W-1:0] dvd_u;
    logic [DVD_W-1:0] dvd_v;
  } front_out_t;

endpackage

`default_nettype wire

### sv/octahedral_normal_encode_top.sv
// ----------------------------------------------------------------------------
// Octahedral normal encoder, top level
// Maps a signed 3-vector onto the octahedral square as two unsigned fractions.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries vec_x, vec_y and vec_z. It is taken
//   when in_valid is high and in_stall is low. The out_ channel returns one
//   request per input with enc_u, enc_v and zero_vector, taken when out_valid
//   is high and out_stall is low. An all-zero vector gives the mid code on
//   both coordinates and raises zero_vector.
//   A request passes three front stages and then one stage per quotient bit
//   of the 16-bit divider; while out_stall is low, throughput is one request per cycle.
//   The divider pipeline, one restoring step per stage, sets the latency.
//   Reset (rst_n low, synchronous) empties every stage. When the receiver
//   stalls, the pipeline keeps filling its empty stages and raises in_stall
//   only when every stage holds a request.
// ----------------------------------------------------------------------------
`default_nettype none

module octahedral_normal_encode_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire octnrm_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output octnrm_pkg::out_item_t      out_data
);

  logic                   in_ready;
  logic                   fo_valid;
  logic                   fo_ready;
  octnrm_pkg::front_out_t fo_data;

  octnrm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fo_valid (fo_valid),
    .fo_ready (fo_ready),
    .fo_data  (fo_data)
  );

  octnrm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .fo_valid  (fo_valid),
    .fo_ready  (fo_ready),
    .fo_data   (fo_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !in_ready;

endmodule

`default_nettype wire

### sv/octnrm_front.sv
// ----------------------------------------------------------------------------
// Octahedral encoder front end
// Three stages: component magnitudes, L1 norm and folded numerators, then the
// scaled and rounded dividends with the divisor 2L.
// ----------------------------------------------------------------------------
`default_nettype none

module octnrm_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire octnrm_pkg::in_item_t  in_data,
  output logic                       fo_valid,
  input  wire logic                  fo_ready,
  output octnrm_pkg::front_out_t     fo_data
);

  localparam int IW = octnrm_pkg::IN_WIDTH;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // Stage 1 registers.
  logic [octnrm_pkg::MAG_W-1:0] ax_r, ay_r, az_r;
  logic                         nx_r, ny_r, nz_r;
  // Stage 2 registers.
  logic [octnrm_pkg::L_W-1:0]   l_r;
  logic [octnrm_pkg::NUM_W-1:0] nu_r, nv_r;
  logic                         zero2_r;
  // Stage 3 registers.
  octnrm_pkg::front_out_t       fo_r;

  logic [IW-1:0] ux, uy, uz;
  logic [octnrm_pkg::MAG_W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [octnrm_pkg::L_W-1:0]   l_nxt;
  logic [octnrm_pkg::NUM_W-1:0] lw, axw, ayw, nu_nxt, nv_nxt;
  octnrm_pkg::front_out_t       fo_nxt;

  assign rdy3     = !v3_r || fo_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    ux = in_data.vec_x;
    uy = in_data.vec_y;
    uz = in_data.vec_z;
    ax_nxt = ux[IW-1] ? (~ux + 1'b1) : ux;
    ay_nxt = uy[IW-1] ? (~uy + 1'b1) : uy;
    az_nxt = uz[IW-1] ? (~uz + 1'b1) : uz;
  end

  always_comb begin
    l_nxt = octnrm_pkg::L_W'(ax_r) + octnrm_pkg::L_W'(ay_r) + octnrm_pkg::L_W'(az_r);
    lw    = octnrm_pkg::NUM_W'(l_nxt);
    axw   = octnrm_pkg::NUM_W'(ax_r);
    ayw   = octnrm_pkg::NUM_W'(ay_r);
    // In the lower hemisphere the triangles fold across the diagonals.
    if (!nz_r) begin
      nu_nxt = nx_r ? (lw - axw) : (lw + axw);
      nv_nxt = ny_r ? (lw - ayw) : (lw + ayw);
    end else begin
      nu_nxt = nx_r ? ayw : ({lw[octnrm_pkg::NUM_W-2:0], 1'b0} - ayw);
      nv_nxt = ny_r ? axw : ({lw[octnrm_pkg::NUM_W-2:0], 1'b0} - axw);
    end
  end

  always_comb begin
    fo_nxt.zero    = zero2_r;
    fo_nxt.divisor = {l_r, 1'b0};
    // Adding L before dividing by 2L rounds to nearest, ties up.
    fo_nxt.dvd_u   = octnrm_pkg::DVD_W'(nu_r) * octnrm_pkg::DVD_W'(octnrm_pkg::OUT_MAX)
                   + octnrm_pkg::DVD_W'(l_r);
    fo_nxt.dvd_v   = octnrm_pkg::DVD_W'(nv_r) * octnrm_pkg::DVD_W'(octnrm_pkg::OUT_MAX)
                   + octnrm_pkg::DVD_W'(l_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
      nx_r <= ux[IW-1];
      ny_r <= uy[IW-1];
      nz_r <= uz[IW-1];
    end
    if (rdy2) begin
      l_r     <= l_nxt;
      nu_r    <= nu_nxt;
      nv_r    <= nv_nxt;
      zero2_r <= (l_nxt == '0);
    end
    if (rdy3) begin
      fo_r <= fo_nxt;
    end
  end

  assign fo_valid = v3_r;
  assign fo_data  = fo_r;

endmodule

`default_nettype wire

### sv/octnrm_div.sv
// ----------------------------------------------------------------------------
// Octahedral encoder divider
// Pipelined restoring divider, one quotient bit per stage, two lanes (u, v)
// sharing the divisor. The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module octnrm_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fo_valid,
  output logic                        fo_ready,
  input  wire octnrm_pkg::front_out_t fo_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output octnrm_pkg::out_item_t       out_data
);

  localparam int NS = octnrm_pkg::DIV_STAGES;
  localparam int NW = octnrm_pkg::NUM_W;
  localparam int OW = octnrm_pkg::OUT_WIDTH;

  logic          vld_r  [NS];
  logic          zero_r [NS];
  logic [NW-1:0] dvs_r  [NS];
  logic [NW-1:0] rem_r  [NS][2];
  logic [OW-1:0] qd_r   [NS][2];

  logic          rdy    [NS+1];
  logic          src_v  [NS];
  logic          src_z  [NS];
  logic [NW-1:0] src_d  [NS];
  logic [NW-1:0] rem_nxt [NS][2];
  logic [OW-1:0] qd_nxt  [NS][2];

  logic [NW-1:0] src_rem [NS][2];
  logic [OW-1:0] src_qd  [NS][2];
  logic [NW:0]   trial   [NS][2];
  logic          ge      [NS][2];

  always_comb begin
    rdy[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign fo_ready = rdy[0];

  // The quotient bits shift in from the right as the dividend bits leave.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        src_v[k]      = fo_valid;
        src_z[k]      = fo_data.zero;
        src_d[k]      = fo_data.divisor;
        src_rem[k][0] = fo_data.dvd_u[octnrm_pkg::DVD_W-1:OW];
        src_qd[k][0]  = fo_data.dvd_u[OW-1:0];
        src_rem[k][1] = fo_data.dvd_v[octnrm_pkg::DVD_W-1:OW];
        src_qd[k][1]  = fo_data.dvd_v[OW-1:0];
      end else begin
        src_v[k]      = vld_r[k-1];
        src_z[k]      = zero_r[k-1];
        src_d[k]      = dvs_r[k-1];
        src_rem[k][0] = rem_r[k-1][0];
        src_qd[k][0]  = qd_r[k-1][0];
        src_rem[k][1] = rem_r[k-1][1];
        src_qd[k][1]  = qd_r[k-1][1];
      end
      for (int j = 0; j < 2; j++) begin
        trial[k][j]   = {src_rem[k][j], src_qd[k][j][OW-1]};
        ge[k][j]      = (trial[k][j] >= {1'b0, src_d[k]});
        rem_nxt[k][j] = ge[k][j] ? NW'(trial[k][j] - {1'b0, src_d[k]}) : trial[k][j][NW-1:0];
        qd_nxt[k][j]  = {src_qd[k][j][OW-2:0], ge[k][j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= src_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        zero_r[k]   <= src_z[k];
        dvs_r[k]    <= src_d[k];
        rem_r[k][0] <= rem_nxt[k][0];
        rem_r[k][1] <= rem_nxt[k][1];
        qd_r[k][0]  <= qd_nxt[k][0];
        qd_r[k][1]  <= qd_nxt[k][1];
      end
    end
  end

  assign out_valid            = vld_r[NS-1];
  assign out_data.enc_u       = zero_r[NS-1] ? octnrm_pkg::OUT_MID : qd_r[NS-1][0];
  assign out_data.enc_v       = zero_r[NS-1] ? octnrm_pkg::OUT_MID : qd_r[NS-1][1];
  assign out_data.zero_vector = zero_r[NS-1];

endmodule

`default_nettype wire

### sv/octnrm_chk.sv
// ----------------------------------------------------------------------------
// Octahedral encoder port checker
// Watches the top-level ports and is bound to every encoder instance.
// ----------------------------------------------------------------------------
`default_nettype none

module octnrm_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire octnrm_pkg::out_item_t out_data
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // The input can only be blocked when the pipe is full behind a stalled output.
  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A zero vector always comes out at the center of the square.
  a_zero_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_vector |->
      out_data.enc_u == octnrm_pkg::OUT_MID && out_data.enc_v == octnrm_pkg::OUT_MID)
    else $error("zero vector not encoded at the mid code");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind octahedral_normal_encode_top octnrm_chk u_octnrm_chk (.*);

`default_nettype wire
